FILE: design/gbpp_pkg.sv
// gbpp_pkg: shared types and constants for the grid path planner
// no dependencies
package gbpp_pkg;

  localparam int unsigned SIDE  = 8;
  localparam int unsigned CELLS = 64;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // expansion order x+1, x-1, y+1, y-1
  localparam logic [1:0] DIR_XP = 2'd0;
  localparam logic [1:0] DIR_XM = 2'd1;
  localparam logic [1:0] DIR_YP = 2'd2;
  localparam logic [1:0] DIR_YM = 2'd3;

  typedef logic [5:0] cell_t;

endpackage

FILE: design/grid_bfs_path_planner.sv
// Grid path planner: an add request with the boat in the grid is accepted, then one S_ADD pass
// marks the boat cell and its in-grid neighbours; a clear request empties the obstacle map as
// it is accepted. A query first copies the obstacle map into the visited map, with the start
// marked and the destination cleared. It then pops one queued cell and checks its four
// neighbours one a cycle through a shared step/compare unit before popping the next. It then
// traces parents back into a path stack, alternating S_TRACE (push) and S_BACK (step back). Last,
// it emits the path one cell a cycle through a single output register, holding while the
// receiver stalls. Failures give a single result with found=0. The block takes no new request
// until the last result of a query has been handed to the output register.
// Depends on gbpp_pkg.
module grid_bfs_path_planner #(
  parameter int unsigned GRID_MAX = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [2:0] pos_x_i,
  input  logic [2:0] pos_y_i,
  input  logic [2:0] dest_x_i,
  input  logic [2:0] dest_y_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] cell_x_o,
  output logic [2:0] cell_y_o,
  output logic       found_o,
  output logic       last_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_INIT, S_POP, S_NBR, S_TRACE, S_BACK, S_EMIT, S_FAIL
  } state_e;

  localparam logic [3:0] SideCap = (GRID_MAX < 8) ? 4'(GRID_MAX) : 4'd8;

  state_e       state_q;
  logic [3:0]   grid_size_q;
  logic [63:0]  obst_q;
  logic [63:0]  vis_q;
  logic [1:0]   par_q [gbpp_pkg::CELLS];
  gbpp_pkg::cell_t queue_q [gbpp_pkg::CELLS];
  gbpp_pkg::cell_t stack_q [gbpp_pkg::CELLS];
  logic [6:0]   head_q, tail_q, cnt_q;
  logic [2:0]   px_q, py_q, qx_q, qy_q;
  gbpp_pkg::cell_t cur_q;
  gbpp_pkg::cell_t stk_rd_q;
  logic [1:0]   dir_q;
  logic         out_valid_q;
  logic [2:0]   cell_x_q, cell_y_q;
  logic         found_q, last_q;

  logic [3:0] side;
  assign side = (grid_size_q > SideCap) ? SideCap : grid_size_q;

  // shared step unit: cell plus/minus one step along dir_q
  logic [3:0] sx, sy, bx, by;
  logic       s_in, b_in;
  always_comb begin
    sx = {1'b0, cur_q[5:3]};
    sy = {1'b0, cur_q[2:0]};
    bx = sx;
    by = sy;
    case (dir_q)
      gbpp_pkg::DIR_XP: begin sx = sx + 4'd1; bx = bx - 4'd1; end
      gbpp_pkg::DIR_XM: begin sx = sx - 4'd1; bx = bx + 4'd1; end
      gbpp_pkg::DIR_YP: begin sy = sy + 4'd1; by = by - 4'd1; end
      gbpp_pkg::DIR_YM: begin sy = sy - 4'd1; by = by + 4'd1; end
      default: ;
    endcase
    s_in = (sx < side) && (sy < side);
    b_in = (bx < 4'd8) && (by < 4'd8);
  end

  gbpp_pkg::cell_t s_cell, b_cell, start_c, dest_c;
  assign s_cell  = {sx[2:0], sy[2:0]};
  assign b_cell  = {bx[2:0], by[2:0]};
  assign start_c = {px_q, py_q};
  assign dest_c  = {qx_q, qy_q};

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc = in_valid_i && in_ready_o;

  logic out_free, emit_go;
  assign out_free = !out_valid_q || out_ready_i;
  assign emit_go  = out_free && (state_q == S_EMIT || state_q == S_FAIL);

  // neighbour taken into the queue this cycle
  logic nbr_take;
  assign nbr_take = (state_q == S_NBR) && (cur_q != dest_c) && s_in && !vis_q[s_cell]
                 && (tail_q < 7'd64);

  logic q_inside, boat_in;
  assign q_inside = ({1'b0, pos_x_i} < side) && ({1'b0, pos_y_i} < side)
                 && ({1'b0, dest_x_i} < side) && ({1'b0, dest_y_i} < side);
  assign boat_in = ({1'b0, pos_x_i} < side) && ({1'b0, pos_y_i} < side);

  // boat neighbour marks for add
  logic [63:0] add_mask;
  always_comb begin
    add_mask = '0;
    for (int d = 0; d < 5; d++) begin
      logic [3:0] ax, ay;
      ax = {1'b0, px_q};
      ay = {1'b0, py_q};
      case (d)
        1: ax = ax + 4'd1;
        2: ax = ax - 4'd1;
        3: ay = ay + 4'd1;
        4: ay = ay - 4'd1;
        default: ;
      endcase
      if (ax < side && ay < side) add_mask[{ax[2:0], ay[2:0]}] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_INIT) queue_q[0] <= start_c;
    if (nbr_take) begin
      queue_q[tail_q[5:0]] <= s_cell;
      par_q[s_cell] <= dir_q;
    end
    if (state_q == S_TRACE) stack_q[cnt_q[5:0]] <= cur_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      grid_size_q <= 4'd8;
      obst_q      <= '0;
      vis_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      dir_q       <= '0;
      px_q        <= '0;
      py_q        <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
      cur_q       <= '0;
      stk_rd_q    <= '0;
      out_valid_q <= 1'b0;
      cell_x_q    <= '0;
      cell_y_q    <= '0;
      found_q     <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_we_i) grid_size_q <= cfg_wdata_i;
      if (emit_go) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_acc) begin
          px_q <= pos_x_i; py_q <= pos_y_i;
          qx_q <= dest_x_i; qy_q <= dest_y_i;
          case (kind_i)
            gbpp_pkg::KIND_CLEAR: obst_q <= '0;
            gbpp_pkg::KIND_ADD:   if (boat_in) state_q <= S_ADD;
            gbpp_pkg::KIND_QUERY: state_q <= q_inside ? S_INIT : S_FAIL;
            default: ;
          endcase
        end
        S_ADD: begin
          obst_q  <= obst_q | add_mask;
          state_q <= S_IDLE;
        end
        S_INIT: begin
          vis_q <= (obst_q & ~(64'd1 << dest_c)) | (64'd1 << start_c);
          head_q <= '0;
          tail_q <= 7'd1;
          state_q <= S_POP;
        end
        S_POP: begin
          cur_q <= queue_q[head_q[5:0]];
          if (head_q < tail_q && head_q < 7'd64) begin
            head_q <= head_q + 7'd1;
            dir_q  <= gbpp_pkg::DIR_XP;
            state_q <= S_NBR;
          end else begin
            state_q <= S_FAIL;
          end
        end
        S_NBR: begin
          if (cur_q == dest_c) begin
            cnt_q <= '0;
            state_q <= S_TRACE;
          end else begin
            if (nbr_take) begin
              vis_q[s_cell] <= 1'b1;
              tail_q <= tail_q + 7'd1;
            end
            dir_q <= dir_q + 2'd1;
            if (dir_q == gbpp_pkg::DIR_YM) state_q <= S_POP;
          end
        end
        // push the cell and fetch the direction that reached it
        S_TRACE: begin
          cnt_q <= cnt_q + 7'd1;
          dir_q <= par_q[cur_q];
          if (cur_q == start_c || cnt_q == 7'd63) begin
            stk_rd_q <= cur_q;
            state_q  <= S_EMIT;
          end else begin
            state_q <= S_BACK;
          end
        end
        // step back to the parent cell
        S_BACK: begin
          if (b_in) begin
            cur_q   <= b_cell;
            state_q <= S_TRACE;
          end else begin
            stk_rd_q <= cur_q;
            state_q  <= S_EMIT;
          end
        end
        S_EMIT: if (out_free) begin
          cell_x_q <= stk_rd_q[5:3];
          cell_y_q <= stk_rd_q[2:0];
          found_q  <= 1'b1;
          last_q   <= (cnt_q == 7'd1);
          stk_rd_q <= stack_q[cnt_q[5:0] - 6'd2];
          cnt_q    <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) state_q <= S_IDLE;
        end
        S_FAIL: if (out_free) begin
          cell_x_q <= '0; cell_y_q <= '0;
          found_q <= 1'b0; last_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_x_o = cell_x_q;
  assign cell_y_o = cell_y_q;
  assign found_o  = found_q;
  assign last_o   = last_q;

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= 7'd64) else $error("queue tail overflow");
  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP || state_q == S_NBR) |-> head_q <= tail_q)
    else $error("queue head past tail");
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> last_o) else $error("fail result not last");
  a_emit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> cnt_q != 7'd0) else $error("empty path emit");

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for grid_bfs_path_planner, with a behavioral path predictor
// and a scoreboard of expected path cells; covers grid sizes, obstacles, queries and stalls
// depends on gbpp_pkg and grid_bfs_path_planner
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCH_LIMIT = 6000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE      = 40;

  typedef struct packed {
    logic [2:0] x;
    logic [2:0] y;
    logic       found;
    logic       last;
  } path_cell_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] kind_i = '0;
  logic [2:0] pos_x_i = '0;
  logic [2:0] pos_y_i = '0;
  logic [2:0] dest_x_i = '0;
  logic [2:0] dest_y_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b1;
  logic [2:0] cell_x_o;
  logic [2:0] cell_y_o;
  logic       found_o;
  logic       last_o;

  // predictor state
  logic [gbpp_pkg::CELLS-1:0] obst_map = '0;
  logic [3:0]       grid_sz = 4'd8;
  path_cell_t       path_q[$];

  int  errors = 0;
  int  n_req = 0;
  int  n_res = 0;
  int  quiet_cycles = 0;
  bit  idle_en = 1'b1;
  bit  hold_req = 1'b0;

  grid_bfs_path_planner #(.GRID_MAX(8)) i_dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic bit in_grid(int x, int y, int n);
    return x >= 0 && y >= 0 && x < n && y < n;
  endfunction

  function automatic void predict_path(logic [1:0] kind, int px, int py, int qx, int qy);
    int         n;
    int         step_x[4];
    int         step_y[4];
    bit         vis[gbpp_pkg::CELLS];
    logic [1:0] par[gbpp_pkg::CELLS];
    int         bfs_q[gbpp_pkg::CELLS];
    int         stk[gbpp_pkg::CELLS];
    int         head, tail, cur, x, y, k, cnt, start, dest;
    bit         hit;
    path_cell_t pc;
    step_x = '{1, -1, 0, 0};
    step_y = '{0, 0, 1, -1};
    n = (grid_sz > 8) ? 8 : grid_sz;
    hit = 1'b0;
    pc = '0;
    if (kind == gbpp_pkg::KIND_CLEAR) begin
      obst_map = '0;
      return;
    end
    if (kind == gbpp_pkg::KIND_ADD) begin
      if (!in_grid(px, py, n)) return;
      obst_map[px*gbpp_pkg::SIDE+py] = 1'b1;
      for (int d = 0; d < 4; d++) begin
        x = px + step_x[d];
        y = py + step_y[d];
        if (in_grid(x, y, n)) obst_map[x*gbpp_pkg::SIDE+y] = 1'b1;
      end
      return;
    end
    if (kind != gbpp_pkg::KIND_QUERY) return;
    if (!in_grid(px, py, n) || !in_grid(qx, qy, n)) begin
      pc.last = 1'b1;
      path_q.insert(path_q.size(), pc);
      return;
    end
    start = px*gbpp_pkg::SIDE + py;
    dest = qx*gbpp_pkg::SIDE + qy;
    for (int i = 0; i < gbpp_pkg::CELLS; i++) vis[i] = obst_map[i];
    vis[dest] = 1'b0;
    head = 0;
    tail = 1;
    bfs_q[0] = start;
    vis[start] = 1'b1;
    while (head < tail) begin
      cur = bfs_q[head];
      head++;
      if (cur == dest) begin
        hit = 1'b1;
        break;
      end
      for (int d = 0; d < 4; d++) begin
        x = cur / gbpp_pkg::SIDE + step_x[d];
        y = cur % gbpp_pkg::SIDE + step_y[d];
        if (in_grid(x, y, n) && !vis[x*gbpp_pkg::SIDE+y]) begin
          k = x*gbpp_pkg::SIDE + y;
          vis[k] = 1'b1;
          par[k] = d[1:0];
          bfs_q[tail] = k;
          tail++;
        end
      end
    end
    if (!hit) begin
      pc.last = 1'b1;
      path_q.insert(path_q.size(), pc);
      return;
    end
    cnt = 0;
    cur = dest;
    while (cnt < gbpp_pkg::CELLS) begin
      stk[cnt] = cur;
      cnt++;
      if (cur == start) break;
      x = cur / gbpp_pkg::SIDE - step_x[par[cur]];
      y = cur % gbpp_pkg::SIDE - step_y[par[cur]];
      if (!in_grid(x, y, gbpp_pkg::SIDE)) break;
      cur = x*gbpp_pkg::SIDE + y;
    end
    for (int i = 0; i < cnt; i++) begin
      pc.x = 3'(stk[cnt-1-i] / gbpp_pkg::SIDE);
      pc.y = 3'(stk[cnt-1-i] % gbpp_pkg::SIDE);
      pc.found = 1'b1;
      pc.last = (i + 1 == cnt);
      path_q.insert(path_q.size(), pc);
    end
  endfunction

  // one request; valid stays high into the next request unless a gap is taken
  task automatic send_req(logic [1:0] kind, logic [2:0] px, logic [2:0] py,
                          logic [2:0] qx, logic [2:0] qy);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    pos_x_i <= px;
    pos_y_i <= py;
    dest_x_i <= qx;
    dest_y_i <= qy;
    do @(posedge clk_i); while (!in_ready_o);
    predict_path(kind, px, py, qx, qy);
    n_req++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (path_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_grid(logic [3:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_sz = v;
  endtask

  task automatic rand_req();
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    n = (grid_sz == 0) ? 1 : ((grid_sz > 8) ? 8 : grid_sz);
    if (sel < 5)
      send_req(gbpp_pkg::KIND_CLEAR, 3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
    else if (sel < 35)
      send_req(gbpp_pkg::KIND_ADD, 3'($urandom_range(0, n-1)), 3'($urandom_range(0, n-1)),
               3'($urandom), 3'($urandom));
    else if (sel < 85)
      send_req(gbpp_pkg::KIND_QUERY, 3'($urandom_range(0, n-1)), 3'($urandom_range(0, n-1)),
               3'($urandom_range(0, n-1)), 3'($urandom_range(0, n-1)));
    else send_req(2'($urandom), 3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
  endtask

  task automatic test_directed();
    send_req(gbpp_pkg::KIND_QUERY, 3'd2, 3'd5, 3'd2, 3'd5);   // start equals destination
    send_req(gbpp_pkg::KIND_QUERY, 3'd0, 3'd0, 3'd7, 3'd7);   // open grid, corner to corner
    send_req(gbpp_pkg::KIND_QUERY, 3'd7, 3'd7, 3'd0, 3'd0);
    send_req(gbpp_pkg::KIND_ADD, 3'd0, 3'd0, 3'd0, 3'd0);
    send_req(gbpp_pkg::KIND_ADD, 3'd7, 3'd7, 3'd7, 3'd7);
    send_req(gbpp_pkg::KIND_QUERY, 3'd0, 3'd0, 3'd7, 3'd7);   // blocked start, freed destination
    send_req(2'd3, 3'd7, 3'd7, 3'd7, 3'd7);                   // unused kind
    // wall across x=3 cuts the grid in two
    for (int y = 0; y < 8; y += 2) send_req(gbpp_pkg::KIND_ADD, 3'd3, y[2:0], 3'd0, 3'd0);
    send_req(gbpp_pkg::KIND_QUERY, 3'd0, 3'd4, 3'd6, 3'd4);   // unreachable
    send_req(gbpp_pkg::KIND_QUERY, 3'd0, 3'd4, 3'd3, 3'd4);   // destination inside the wall
    send_req(gbpp_pkg::KIND_CLEAR, 3'd0, 3'd0, 3'd0, 3'd0);
    send_req(gbpp_pkg::KIND_QUERY, 3'd0, 3'd4, 3'd6, 3'd4);
    set_grid(4'd3);
    send_req(gbpp_pkg::KIND_ADD, 3'd5, 3'd1, 3'd0, 3'd0);     // boat outside grid
    send_req(gbpp_pkg::KIND_ADD, 3'd2, 3'd2, 3'd0, 3'd0);     // edge neighbours clipped
    send_req(gbpp_pkg::KIND_QUERY, 3'd5, 3'd0, 3'd0, 3'd0);   // start outside
    send_req(gbpp_pkg::KIND_QUERY, 3'd0, 3'd0, 3'd0, 3'd6);   // destination outside
    send_req(gbpp_pkg::KIND_QUERY, 3'd0, 3'd0, 3'd2, 3'd2);
    set_grid(4'd0);
    send_req(gbpp_pkg::KIND_ADD, 3'd0, 3'd0, 3'd0, 3'd0);
    send_req(gbpp_pkg::KIND_QUERY, 3'd0, 3'd0, 3'd0, 3'd0);
    set_grid(4'd1);
    send_req(gbpp_pkg::KIND_QUERY, 3'd0, 3'd0, 3'd0, 3'd0);
    set_grid(4'd15);
    send_req(gbpp_pkg::KIND_QUERY, 3'd7, 3'd0, 3'd0, 3'd7);
  endtask

  task automatic test_random();
    logic [3:0] sizes[8];
    sizes = '{4'd8, 4'd2, 4'd5, 4'd15, 4'd1, 4'd7, 4'd0, 4'd8};
    foreach (sizes[i]) begin
      set_grid(sizes[i]);
      send_req(gbpp_pkg::KIND_CLEAR, 3'd0, 3'd0, 3'd0, 3'd0);
      repeat (42) rand_req();
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = 1'b1;
    repeat (20)
      send_req(gbpp_pkg::KIND_QUERY, 3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
  endtask

  task automatic test_no_idle();
    drain();
    idle_en = 1'b0;
    repeat (40) rand_req();
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // scoreboard check of each path cell
  always @(posedge clk_i) begin
    path_cell_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_res++;
      if (path_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d found=%0d last=%0d",
               cell_x_o, cell_y_o, found_o, last_o);
        errors++;
      end else begin
        want = path_q.pop_front();
        if (cell_x_o !== want.x) begin
          $error("cell_x expected %0d got %0d", want.x, cell_x_o);
          errors++;
        end
        if (cell_y_o !== want.y) begin
          $error("cell_y expected %0d got %0d", want.y, cell_y_o);
          errors++;
        end
        if (found_o !== want.found) begin
          $error("found expected %0d got %0d", want.found, found_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last expected %0d got %0d", want.last, last_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("watchdog: no progress, %0d results outstanding", path_q.size());
      $display("** grid_bfs_path_planner: FAILED **");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    test_no_idle();
    drain();
    $display("covered %0d requests and %0d path results over grid sizes 0..15,",
             n_req, n_res);
    $display("with obstacles, unreachable and out-of-grid queries, and output stalls");
    if (errors == 0 && path_q.size() == 0) begin
      $display("** grid_bfs_path_planner: PASSED **");
    end else begin
      $display("** grid_bfs_path_planner: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/gbpp_pkg.sv
design/grid_bfs_path_planner.sv
tb/tb_top.sv
